>>> design/slr_pkg.sv
package slr_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int STEP_W     = 18;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] REG_STEP_RATIO = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MONO_INPUT = 4'd1;

   localparam int IQ_DEPTH  = 2;
   localparam int IQ_PTR_W  = 1;
   localparam int IQ_CNT_W  = 2;

   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = 3;
   localparam int OUT_CNT_W = 4;

   localparam int LANE_LAT  = 4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       restart;
   } slr_frame_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       last;
   } slr_result_type;

endpackage

>>> design/slr_front.sv
module slr_front import slr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mono_input,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   input  logic                       req_restart,
   input  logic                       q_pop,
   output logic                       q_valid,
   output slr_frame_type              q_frame
);

   slr_frame_type       mem_ff [IQ_DEPTH];
   logic [IQ_PTR_W-1:0] wr_ff, wr_in;
   logic [IQ_PTR_W-1:0] rd_ff, rd_in;
   logic [IQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                push;
   slr_frame_type       frame;

   assign req_stall = (cnt_ff == IQ_CNT_W'(IQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_frame   = mem_ff[rd_ff];

   always_comb begin
      frame.left    = req_left_in;
      frame.right   = mono_input ? req_left_in : req_right_in;
      frame.restart = req_restart;
   end

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = (q_pop && q_valid) ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + IQ_CNT_W'(push) - IQ_CNT_W'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> design/slr_lane.sv
module slr_lane import slr_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                       clock,
   input  logic signed [SAMPLE_W-1:0] a,
   input  logic signed [SAMPLE_W-1:0] b,
   input  logic [FRACTION_BITS-1:0]   frac,
   output logic signed [SAMPLE_W-1:0] y
);

   localparam int PW    = FRACTION_BITS + 18;
   localparam int NW    = PW + 15;
   localparam int SH    = FRACTION_BITS + 15;
   localparam int QW    = NW - SH;

   logic signed [SAMPLE_W:0]        diff;
   logic signed [FRACTION_BITS:0]   frac_s;
   logic signed [PW-1:0]            prod_in, prod_ff;
   logic signed [SAMPLE_W-1:0]      a_ff;
   logic signed [PW-1:0]            acc_in, acc_ff;
   logic signed [NW-1:0]            num;
   logic signed [QW-1:0]            q_in, q_ff;
   logic                            inc_in, inc_ff;
   logic signed [QW:0]              sum;
   logic signed [SAMPLE_W-1:0]      y_in, y_ff;

   assign diff    = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
   assign frac_s  = {1'b0, frac};
   assign prod_in = PW'(diff) * PW'(frac_s);
   assign acc_in  = (PW'(a_ff) <<< FRACTION_BITS) + prod_ff;
   assign num     = (NW'(acc_ff) <<< 15) - NW'(acc_ff);
   assign q_in    = num[NW-1:SH];
   // round half to even
   assign inc_in  = num[SH-1] && ((num[SH-2:0] != '0) || num[SH]);
   assign sum     = {q_ff[QW-1], q_ff} + {{QW{1'b0}}, inc_ff};

   always_comb begin
      if (sum > (QW+1)'(32767)) begin
         y_in = 16'sh7FFF;
      end else if (sum < -(QW+1)'(32768)) begin
         y_in = 16'sh8000;
      end else begin
         y_in = sum[SAMPLE_W-1:0];
      end
   end

   assign y = y_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a;
      acc_ff  <= acc_in;
      q_ff    <= q_in;
      inc_ff  <= inc_in;
      y_ff    <= y_in;
   end

endmodule

>>> design/slr_back.sv
module slr_back import slr_pkg::*; #(
   parameter int MAX_OUTPUTS_PER_INPUT = 8,
   parameter int FRACTION_BITS         = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [STEP_W-1:0]          step_ratio,
   input  slr_frame_type              q_frame,
   input  logic                       q_valid,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic                       rsp_last_of_run
);

   localparam int SW = (FRACTION_BITS + 2 > STEP_W) ? FRACTION_BITS + 2 : STEP_W;
   localparam int RW = SW + 1;
   localparam int CW = (MAX_OUTPUTS_PER_INPUT > 1) ? $clog2(MAX_OUTPUTS_PER_INPUT) : 1;
   localparam logic [RW-1:0] PH_ONE = RW'(1) << FRACTION_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } slr_state_type;

   slr_state_type              state_ff, state_in;
   logic [SW-1:0]              phase_ff, phase_in;
   logic [SW-1:0]              run_ff, run_in;
   logic [CW-1:0]              count_ff, count_in;
   logic signed [SAMPLE_W-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [SAMPLE_W-1:0] cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic [SW-1:0]              start_ph;
   logic [RW-1:0]              start_ext;
   logic [RW-1:0]              next_ph;
   logic                       run_end;
   logic                       issue;
   logic [LANE_LAT-1:0]        vld_ff, vld_in;
   logic [LANE_LAT-1:0]        last_ff, last_in;
   logic [OUT_CNT_W-1:0]       rsv_ff, rsv_in;
   logic signed [SAMPLE_W-1:0] lane_l, lane_r;
   slr_result_type             omem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]       owr_ff, owr_in, ord_ff, ord_in;
   logic [OUT_CNT_W-1:0]       ocnt_ff, ocnt_in;
   logic                       opush, opop;
   slr_result_type             ohead;

   assign start_ph  = q_frame.restart ? '0 : phase_ff;
   assign start_ext = {1'b0, start_ph};
   assign next_ph   = {1'b0, run_ff} + RW'(step_ratio);
   assign run_end   = (next_ph >= PH_ONE) || (count_ff == CW'(MAX_OUTPUTS_PER_INPUT - 1));
   assign issue     = (state_ff == ST_RUN) && (rsv_ff < OUT_CNT_W'(OUT_DEPTH));
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      run_in    = run_ff;
      count_in  = count_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      cur_l_in  = cur_l_ff;
      cur_r_in  = cur_r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (start_ext >= PH_ONE) begin
                  // downsampling skip: no output, drop one period
                  phase_in  = SW'(start_ext - PH_ONE);
                  prev_l_in = q_frame.left;
                  prev_r_in = q_frame.right;
               end else begin
                  state_in = ST_RUN;
                  run_in   = start_ph;
                  count_in = '0;
                  cur_l_in = q_frame.left;
                  cur_r_in = q_frame.right;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (run_end) begin
                  phase_in  = (next_ph >= PH_ONE) ? SW'(next_ph - PH_ONE) : '0;
                  prev_l_in = cur_l_ff;
                  prev_r_in = cur_r_ff;
                  state_in  = ST_IDLE;
               end else begin
                  run_in   = SW'(next_ph);
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   slr_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_l (
      .clock (clock),
      .a     (prev_l_ff),
      .b     (cur_l_ff),
      .frac  (run_ff[FRACTION_BITS-1:0]),
      .y     (lane_l)
   );

   slr_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_r (
      .clock (clock),
      .a     (prev_r_ff),
      .b     (cur_r_ff),
      .frac  (run_ff[FRACTION_BITS-1:0]),
      .y     (lane_r)
   );

   assign vld_in  = {vld_ff[LANE_LAT-2:0], issue};
   assign last_in = {last_ff[LANE_LAT-2:0], run_end};

   assign opush = vld_ff[LANE_LAT-1];
   assign opop  = rsp_valid && !rsp_stall;
   assign ohead = omem_ff[ord_ff];

   assign rsp_valid       = (ocnt_ff != '0);
   assign rsp_left_out    = ohead.left;
   assign rsp_right_out   = ohead.right;
   assign rsp_last_of_run = ohead.last;

   always_comb begin
      rsv_in  = rsv_ff + OUT_CNT_W'(issue) - OUT_CNT_W'(opop);
      ocnt_in = ocnt_ff + OUT_CNT_W'(opush) - OUT_CNT_W'(opop);
      owr_in  = opush ? owr_ff + 1'b1 : owr_ff;
      ord_in  = opop ? ord_ff + 1'b1 : ord_ff;
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         omem_ff[owr_ff] <= '{left: lane_l, right: lane_r, last: last_ff[LANE_LAT-1]};
      end
   end

   always_ff @(posedge clock) begin
      run_ff   <= run_in;
      count_ff <= count_in;
      cur_l_ff <= cur_l_in;
      cur_r_ff <= cur_r_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= '0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         vld_ff    <= '0;
         rsv_ff    <= '0;
         ocnt_ff   <= '0;
         owr_ff    <= '0;
         ord_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
         vld_ff    <= vld_in;
         rsv_ff    <= rsv_in;
         ocnt_ff   <= ocnt_in;
         owr_ff    <= owr_in;
         ord_ff    <= ord_in;
      end
   end

endmodule

>>> design/stereo_linear_resampler_core.sv
// Stereo linear-interpolation rate converter.
// req_ channel: one s16 stereo frame per beat plus a restart flag that clears
// the phase before the frame. rsp_ channel: interpolated s16 stereo frames,
// last_of_run marks the final beat caused by one input frame. Both channels
// use valid/stall; a beat moves when valid is high and stall is low.
// csr_ channel: valid/ready writes, index 0 step_ratio (Q2.FRACTION_BITS),
// index 1 mono_input; other indexes are ignored. Write only while idle.
// A frame accepted on req_ passes the input queue, the sequencer, the lanes
// and the result queue before its first result beat is offered on rsp_.
// Throughput: the back-end sequencer issues one result per cycle while the
// result queue has room, and pops the next frame only from idle once the run
// of the last one has ended; a frame causing no result is dropped in idle. Up to
// MAX_OUTPUTS_PER_INPUT results per frame.
// A two-entry input queue and an eight-entry result queue decouple the
// sides; when rsp_stall holds, the result queue fills, the sequencer holds,
// then the input queue fills and req_stall rises.
// Reset: phase and previous frame clear to zero, step_ratio to unity,
// mono_input to 0, both queues empty.
module stereo_linear_resampler_core import slr_pkg::*; #(
   parameter int MAX_OUTPUTS_PER_INPUT = 8,
   parameter int FRACTION_BITS         = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic                       rsp_last_of_run
);

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd1 << FRACTION_BITS);

   logic [STEP_W-1:0]  step_ff, step_in;
   logic               mono_ff, mono_in;
   logic               q_valid, q_pop;
   slr_frame_type      q_frame;

   assign csr_ready = 1'b1;

   always_comb begin
      step_in = step_ff;
      mono_in = mono_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_STEP_RATIO: step_in = csr_data[STEP_W-1:0];
            REG_MONO_INPUT: mono_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         mono_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         mono_ff <= mono_in;
      end
   end

   slr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .mono_input   (mono_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_left_in  (req_left_in),
      .req_right_in (req_right_in),
      .req_restart  (req_restart),
      .q_pop        (q_pop),
      .q_valid      (q_valid),
      .q_frame      (q_frame)
   );

   slr_back #(
      .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT),
      .FRACTION_BITS         (FRACTION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .step_ratio      (step_ff),
      .q_frame         (q_frame),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> tb/tb_stereo_linear_resampler_core.sv
module tb_stereo_linear_resampler_core;
   timeunit 1ns;
   timeprecision 1ps;

   import slr_pkg::*;

   localparam int MAX_OUT      = 8;
   localparam int FRAC_W       = 16;
   localparam int PHASE_ONE    = 1 << FRAC_W;
   localparam int DRAIN_CYCLES = 24;
   localparam int SETTLE_LIMIT = 20000;
   localparam int SEG_ITEMS    = 50;
   localparam int NUM_SEGS     = 7;
   localparam int HOLD_CYCLES  = 400;
   localparam int DUE_IDX_W    = 8;
   localparam int DUE_DEPTH    = 1 << DUE_IDX_W;
   localparam int DIR_IDX_W    = 6;
   localparam int DIR_ROWS     = 1 << DIR_IDX_W;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 4'd15;

   localparam logic [STEP_W-1:0] STEP_UNITY = 18'd65536;
   localparam logic [STEP_W-1:0] STEP_MIN   = 18'd8192;
   localparam logic [STEP_W-1:0] STEP_MAX   = 18'h3FFFF;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_IDX_W-1:0]       idx;
      logic [CSR_DATA_W-1:0]      data;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       restart;
      logic                       known;
      logic signed [SAMPLE_W-1:0] want_left;
      logic signed [SAMPLE_W-1:0] want_right;
   } stim_row_type;

   logic                       clock;
   logic                       reset        = 1'b1;
   logic                       csr_valid    = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index    = '0;
   logic [CSR_DATA_W-1:0]      csr_data     = '0;
   logic                       req_valid    = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_left_in  = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic                       req_restart  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall    = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       rsp_last_of_run;

   logic                       hold_rsp     = 1'b0;
   bit                         pressure_req = 1'b0;
   bit                         failed       = 1'b0;
   int                         src_idle_pct  = 30;
   int                         sink_idle_pct = 57;

   logic [STEP_W-1:0]          cfg_step  = STEP_UNITY;
   logic                       cfg_mono  = 1'b0;
   logic [STEP_W-1:0]          phase_q   = '0;
   logic signed [SAMPLE_W-1:0] last_left  = '0;
   logic signed [SAMPLE_W-1:0] last_right = '0;

   slr_result_type             due_beats [DUE_DEPTH];
   int                         due_head = 0;
   int                         due_tail = 0;
   stim_row_type               dir_tbl [DIR_ROWS];
   int                         dir_rows = 0;

   stereo_linear_resampler_core #(
      .MAX_OUTPUTS_PER_INPUT(MAX_OUT),
      .FRACTION_BITS(FRAC_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("stereo_linear_resampler_core test failed");
      $finish;
   end

   function automatic void due_put(input slr_result_type beat);
      due_beats[DUE_IDX_W'(due_tail)] = beat;
      due_tail++;
   endfunction

   function automatic slr_result_type due_take();
      slr_result_type beat;
      beat = due_beats[DUE_IDX_W'(due_head)];
      due_head++;
      return beat;
   endfunction

   function automatic int due_count();
      return due_tail - due_head;
   endfunction

   function automatic void add_row(input stim_row_type row);
      dir_tbl[DIR_IDX_W'(dir_rows)] = row;
      dir_rows++;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] blend_sample(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b,
      input logic [FRAC_W-1:0]          frac
   );
      longint          acc;
      longint          num;
      longint          res;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned rem;
      longint unsigned half;
      bit              neg;
      acc  = longint'(a) * PHASE_ONE + (longint'(b) - longint'(a)) * longint'({1'b0, frac});
      num  = acc * 32767;
      neg  = num < 0;
      mag  = neg ? longint'(-num) : num;
      q    = mag >> (15 + FRAC_W);
      rem  = mag & ((64'd1 << (15 + FRAC_W)) - 64'd1);
      half = 64'd1 << (14 + FRAC_W);
      if (rem > half || (rem == half && q[0]))
         q = q + 1;
      res = neg ? -longint'(q) : longint'(q);
      if (res > 32767)
         res = 32767;
      if (res < -32768)
         res = -32768;
      return res[SAMPLE_W-1:0];
   endfunction

   function automatic void predict_frame(
      input logic signed [SAMPLE_W-1:0] l,
      input logic signed [SAMPLE_W-1:0] r,
      input logic                       rs,
      input bit                         emit
   );
      logic signed [SAMPLE_W-1:0] nl;
      logic signed [SAMPLE_W-1:0] nr;
      logic [STEP_W:0]            ph;
      logic [STEP_W:0]            ph_next;
      slr_result_type             beat;
      int                         n;
      nl = l;
      nr = cfg_mono ? l : r;
      ph = {1'b0, phase_q};
      if (rs)
         ph = '0;
      n = 0;
      while (ph < PHASE_ONE && n < MAX_OUT) begin
         ph_next    = ph + cfg_step;
         beat.left  = blend_sample(last_left, nl, ph[FRAC_W-1:0]);
         beat.right = blend_sample(last_right, nr, ph[FRAC_W-1:0]);
         beat.last  = (ph_next >= PHASE_ONE) || (n == MAX_OUT - 1);
         if (emit)
            due_put(beat);
         ph = ph_next;
         n++;
      end
      // saturate at zero when the cap ends the run early
      ph         = (ph >= PHASE_ONE) ? ph - (STEP_W+1)'(PHASE_ONE) : '0;
      phase_q    = ph[STEP_W-1:0];
      last_left  = nl;
      last_right = nr;
   endfunction

   function automatic void check_beat();
      slr_result_type want;
      if (due_count() == 0) begin
         $error("result beat with none expected: left_out %0d right_out %0d last_of_run %0b",
                rsp_left_out, rsp_right_out, rsp_last_of_run);
         failed = 1'b1;
      end else begin
         want = due_take();
         if (rsp_left_out !== want.left) begin
            $error("left_out: expected %0d, actual %0d", want.left, rsp_left_out);
            failed = 1'b1;
         end
         if (rsp_right_out !== want.right) begin
            $error("right_out: expected %0d, actual %0d", want.right, rsp_right_out);
            failed = 1'b1;
         end
         if (rsp_last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, rsp_last_of_run);
            failed = 1'b1;
         end
      end
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx, input int data);
      stim_row_type row;
      row      = '0;
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.data = data[CSR_DATA_W-1:0];
      return row;
   endfunction

   function automatic stim_row_type frame_row(input int l, input int r, input bit rs);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_FRAME;
      row.left    = l[SAMPLE_W-1:0];
      row.right   = r[SAMPLE_W-1:0];
      row.restart = rs;
      return row;
   endfunction

   function automatic stim_row_type known_row(input int l, input int r, input bit rs,
                                              input int el, input int er);
      stim_row_type row;
      row            = frame_row(l, r, rs);
      row.known      = 1'b1;
      row.want_left  = el[SAMPLE_W-1:0];
      row.want_right = er[SAMPLE_W-1:0];
      return row;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_frame(
      input logic signed [SAMPLE_W-1:0] l,
      input logic signed [SAMPLE_W-1:0] r,
      input logic                       rs,
      input bit                         known,
      input logic signed [SAMPLE_W-1:0] el,
      input logic signed [SAMPLE_W-1:0] er
   );
      slr_result_type beat;
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= l;
      req_right_in <= r;
      req_restart  <= rs;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_frame(l, r, rs, !known);
      if (known) begin
         beat.left  = el;
         beat.right = er;
         beat.last  = 1'b1;
         due_put(beat);
      end
   endtask

   task automatic drain_block();
      int k;
      req_valid <= 1'b0;
      for (k = 0; k < SETTLE_LIMIT && due_count() != 0; k++)
         @(posedge clock);
      if (due_count() != 0) begin
         $error("%0d result beats never arrived", due_count());
         failed = 1'b1;
         due_head = due_tail;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx == REG_STEP_RATIO)
         cfg_step = data[STEP_W-1:0];
      else if (idx == REG_MONO_INPUT)
         cfg_mono = data[0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // receiver side: check each beat, then pick the next stall
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            check_beat();
         rsp_stall <= hold_rsp || ($urandom_range(99) < sink_idle_pct);
      end
   end

   // long hold-off on the result side
   initial begin
      wait (pressure_req);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      int                seg;
      int                i;
      stim_row_type      row;
      logic [STEP_W-1:0] step;
      logic              mono;

      add_row(known_row(32767, -32768, 0, 0, 0));
      add_row(known_row(-32768, 32767, 0, 32766, -32767));
      add_row(known_row(0, 0, 0, -32767, 32766));
      add_row(known_row(12345, -12345, 1, 0, 0));
      add_row(frame_row(-1, 1, 0));
      add_row(csr_row(REG_STEP_RATIO, 40000));
      add_row(frame_row(32767, 32767, 0));
      add_row(frame_row(-32768, -32768, 0));
      add_row(frame_row(1000, -1000, 1));
      add_row(csr_row(REG_STEP_RATIO, int'(STEP_MIN)));
      add_row(frame_row(32767, -32768, 0));
      add_row(frame_row(-32768, 32767, 0));
      add_row(csr_row(REG_STEP_RATIO, 3000));
      add_row(frame_row(20000, -20000, 0));
      add_row(frame_row(-5, 5, 1));
      add_row(csr_row(REG_STEP_RATIO, int'(STEP_MAX)));
      add_row(frame_row(32767, 32767, 0));
      add_row(frame_row(-32768, -32768, 0));
      add_row(frame_row(111, -222, 1));
      add_row(frame_row(-32768, 32767, 0));
      add_row(frame_row(4096, -4096, 0));
      add_row(csr_row(REG_MONO_INPUT, 1));
      add_row(frame_row(30000, -30000, 0));
      add_row(frame_row(-32768, 32767, 1));
      add_row(frame_row(7, -7, 0));
      add_row(csr_row(REG_SPARE_LO, int'(STEP_MAX)));
      add_row(csr_row(REG_SPARE_HI, 0));
      add_row(csr_row(REG_STEP_RATIO, int'(STEP_UNITY)));
      add_row(frame_row(-300, 300, 0));
      add_row(csr_row(REG_MONO_INPUT, 2));
      add_row(frame_row(100, 200, 0));
      add_row(frame_row(32767, -32768, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < dir_rows; i++) begin
         row = dir_tbl[DIR_IDX_W'(i)];
         if (row.kind == ROW_CSR) begin
            drain_block();
            write_reg(row.idx, row.data);
         end else begin
            send_frame(row.left, row.right, row.restart,
                       row.known, row.want_left, row.want_right);
         end
      end

      for (seg = 0; seg < NUM_SEGS; seg++) begin
         drain_block();
         if (seg < 2) begin
            src_idle_pct  = 30;
            sink_idle_pct = 57;
         end else if (seg < 4) begin
            src_idle_pct  = 57;
            sink_idle_pct = 30;
         end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         case (seg)
            0: begin
               step = STEP_W'($urandom_range(STEP_MAX, STEP_MIN));
               mono = 1'($urandom_range(1));
            end
            1: begin
               step = STEP_MIN;
               mono = 1'b0;
            end
            2: begin
               step = STEP_MAX;
               mono = 1'b1;
            end
            3: begin
               step = STEP_W'($urandom_range(STEP_MIN - 1, 0));
               mono = 1'b0;
            end
            4: begin
               step = STEP_UNITY;
               mono = 1'($urandom_range(1));
            end
            5: begin
               step = STEP_W'($urandom_range(131072, STEP_MIN));
               mono = 1'b0;
            end
            default: begin
               step = STEP_W'($urandom_range(STEP_MAX, STEP_MIN));
               mono = 1'b1;
            end
         endcase
         write_reg(REG_STEP_RATIO, step);
         write_reg(REG_MONO_INPUT, {{(CSR_DATA_W-1){1'b0}}, mono});
         if (seg == 4)
            pressure_req = 1'b1;
         repeat (SEG_ITEMS)
            send_frame(rand_sample(), rand_sample(), ($urandom_range(99) < 8),
                       1'b0, '0, '0);
      end

      drain_block();
      if (!failed)
         $display("stereo_linear_resampler_core test passed");
      else
         $display("stereo_linear_resampler_core test failed");
      $finish;
   end

endmodule

>>> sim.f
design/slr_pkg.sv
design/slr_front.sv
design/slr_lane.sv
design/slr_back.sv
design/stereo_linear_resampler_core.sv
tb/tb_stereo_linear_resampler_core.sv
